>>> hw/rtl/rstat_pkg.sv
package rstat_pkg;

	// fixed-point fraction bits of mean and deviation
	localparam int FRAC = 8;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_CAPTURE,
		CMD_UPDATE,
		CMD_MEAN_LOAD,
		CMD_DIV_STEP,
		CMD_MEAN_TAKE,
		CMD_MULA_LOAD,
		CMD_MUL_STEP,
		CMD_MULB_LOAD,
		CMD_DEN,
		CMD_VAR_LOAD,
		CMD_ROOT_LOAD,
		CMD_ROOT_STEP,
		CMD_OUT_LOAD
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_MEAN_LOAD,
		ST_MEAN_DIV,
		ST_MEAN_TAKE,
		ST_MULA_LOAD,
		ST_MULA,
		ST_MULB_LOAD,
		ST_MULB,
		ST_DEN,
		ST_VAR_LOAD,
		ST_VAR_DIV,
		ST_ROOT_LOAD,
		ST_ROOT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		cmd_t op;
	} ctl_t;

	typedef struct packed {
		logic two_plus;
		logic out_free;
	} stat_t;

endpackage

>>> hw/rtl/rstat_ctrl.sv
module rstat_ctrl #(
	parameter int COUNT_BITS  = 24,
	parameter int SAMPLE_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  rstat_pkg::stat_t stat,
	output rstat_pkg::ctl_t  ctl
);
	import rstat_pkg::*;

	localparam int TB       = COUNT_BITS + SAMPLE_BITS;
	localparam int FIX      = SAMPLE_BITS + FRAC;
	localparam int DW       = 2 * TB + 2 * FRAC;
	localparam int SW       = $clog2(DW + 1);
	localparam int MEAN_LEN = TB + FRAC;

	state_t        state_q, state_d;
	logic [SW-1:0] step_q;
	logic          step_clr;

	// state register and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (step_clr)
				step_q <= '0;
			else
				step_q <= step_q + 1'b1;
		end
	end

	// next state and command
	always_comb begin
		state_d  = state_q;
		ctl.op   = CMD_NONE;
		step_clr = 1'b1;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					ctl.op  = CMD_CAPTURE;
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				ctl.op  = CMD_UPDATE;
				state_d = ST_MEAN_LOAD;
			end
			ST_MEAN_LOAD: begin
				ctl.op  = CMD_MEAN_LOAD;
				state_d = ST_MEAN_DIV;
			end
			ST_MEAN_DIV: begin
				ctl.op   = CMD_DIV_STEP;
				step_clr = 1'b0;
				if (step_q == SW'(MEAN_LEN - 1)) begin
					step_clr = 1'b1;
					state_d  = ST_MEAN_TAKE;
				end
			end
			ST_MEAN_TAKE: begin
				ctl.op  = CMD_MEAN_TAKE;
				state_d = stat.two_plus ? ST_MULA_LOAD : ST_FINISH;
			end
			ST_MULA_LOAD: begin
				ctl.op  = CMD_MULA_LOAD;
				state_d = ST_MULA;
			end
			ST_MULA: begin
				ctl.op   = CMD_MUL_STEP;
				step_clr = 1'b0;
				if (step_q == SW'(COUNT_BITS - 1)) begin
					step_clr = 1'b1;
					state_d  = ST_MULB_LOAD;
				end
			end
			ST_MULB_LOAD: begin
				ctl.op  = CMD_MULB_LOAD;
				state_d = ST_MULB;
			end
			ST_MULB: begin
				ctl.op   = CMD_MUL_STEP;
				step_clr = 1'b0;
				if (step_q == SW'(TB - 1)) begin
					step_clr = 1'b1;
					state_d  = ST_DEN;
				end
			end
			ST_DEN: begin
				ctl.op  = CMD_DEN;
				state_d = ST_VAR_LOAD;
			end
			ST_VAR_LOAD: begin
				ctl.op  = CMD_VAR_LOAD;
				state_d = ST_VAR_DIV;
			end
			ST_VAR_DIV: begin
				ctl.op   = CMD_DIV_STEP;
				step_clr = 1'b0;
				if (step_q == SW'(DW - 1)) begin
					step_clr = 1'b1;
					state_d  = ST_ROOT_LOAD;
				end
			end
			ST_ROOT_LOAD: begin
				ctl.op  = CMD_ROOT_LOAD;
				state_d = ST_ROOT;
			end
			ST_ROOT: begin
				ctl.op   = CMD_ROOT_STEP;
				step_clr = 1'b0;
				if (step_q == SW'(FIX - 1)) begin
					step_clr = 1'b1;
					state_d  = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					ctl.op  = CMD_OUT_LOAD;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> hw/rtl/rstat_dp.sv
module rstat_dp #(
	parameter int COUNT_BITS  = 24,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  rstat_pkg::ctl_t                               ctl,
	output rstat_pkg::stat_t                              stat,
	input  logic signed [SAMPLE_BITS-1:0]                 sample,
	output logic                                          out_valid,
	input  logic                                          out_stall,
	output logic [COUNT_BITS-1:0]                         count,
	output logic signed [COUNT_BITS+SAMPLE_BITS-1:0]      total,
	output logic signed [SAMPLE_BITS-1:0]                 smallest,
	output logic signed [SAMPLE_BITS-1:0]                 largest,
	output logic signed [SAMPLE_BITS+rstat_pkg::FRAC-1:0] mean,
	output logic [SAMPLE_BITS+rstat_pkg::FRAC-1:0]        deviation,
	output logic                                          deviation_valid,
	output logic                                          dropped
);
	import rstat_pkg::*;

	localparam int C   = COUNT_BITS;
	localparam int S   = SAMPLE_BITS;
	localparam int TB  = C + S;
	localparam int SQ  = C + 2 * S - 2;
	localparam int FIX = S + FRAC;
	localparam int W   = 2 * TB + 1;
	localparam int DW  = W - 1 + 2 * FRAC;
	localparam int DV  = 2 * C;
	localparam int QW  = 2 * FIX;

	// running state
	logic [C-1:0]         cnt_q;
	logic signed [TB-1:0] sum_q;
	logic [SQ-1:0]        sq_q;
	logic signed [S-1:0]  min_q, max_q;
	logic                 drop_q;

	// captured sample and its square
	logic signed [S-1:0] samp_q;
	logic [2*S-1:0]      sqr;
	logic [S-1:0]        mag;

	// shared divider, multiplier and root
	logic [DW-1:0]  num_q;
	logic [DV-1:0]  den_q, rem_q;
	logic [QW-1:0]  quo_q;
	logic [W-1:0]   prod_q, mcand_q;
	logic [TB-1:0]  mplier_q;
	logic           sub_q, neg_q;
	logic [QW-1:0]  v_q, res_q, bit_q;
	logic [FIX-1:0] mean_q;

	logic [TB-1:0]  abs_sum;
	logic [DV:0]    rem2;
	logic [QW-1:0]  trial;
	logic [FIX-1:0] qlow;
	logic           two_plus;

	assign mag      = samp_q[S-1] ? (~samp_q + 1'b1) : samp_q;
	assign sqr      = (2*S)'(mag) * (2*S)'(mag);
	assign abs_sum  = sum_q[TB-1] ? (~sum_q + 1'b1) : sum_q;
	assign rem2     = {rem_q, num_q[DW-1]};
	assign trial    = res_q + bit_q;
	assign qlow     = quo_q[FIX-1:0];
	assign two_plus = (cnt_q[C-1:1] != '0);

	assign stat.two_plus = two_plus;
	assign stat.out_free = !out_valid || !out_stall;

	// statistics update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			sum_q  <= '0;
			sq_q   <= '0;
			min_q  <= '0;
			max_q  <= '0;
			drop_q <= 1'b0;
		end else if (ctl.op == CMD_UPDATE) begin
			drop_q <= (cnt_q == '1);
			if (cnt_q != '1) begin
				cnt_q <= cnt_q + 1'b1;
				sum_q <= sum_q + {{(TB-S){samp_q[S-1]}}, samp_q};
				sq_q  <= sq_q + SQ'(sqr);
				if (cnt_q == '0 || samp_q < min_q)
					min_q <= samp_q;
				if (cnt_q == '0 || samp_q > max_q)
					max_q <= samp_q;
			end
		end
	end

	// sample capture; its square is formed during the update
	always_ff @(posedge clk) begin
		if (ctl.op == CMD_CAPTURE)
			samp_q <= sample;
	end

	// restoring divider, shift-add multiplier, digit-pair square root
	always_ff @(posedge clk) begin
		case (ctl.op)
			CMD_MEAN_LOAD: begin
				num_q <= {abs_sum, {FRAC{1'b0}}, {(DW-TB-FRAC){1'b0}}};
				den_q <= DV'(cnt_q);
				rem_q <= '0;
				quo_q <= '0;
			end
			CMD_DIV_STEP: begin
				num_q <= {num_q[DW-2:0], 1'b0};
				if (rem2 >= {1'b0, den_q}) begin
					rem_q <= DV'(rem2 - {1'b0, den_q});
					quo_q <= {quo_q[QW-2:0], 1'b1};
				end else begin
					rem_q <= rem2[DV-1:0];
					quo_q <= {quo_q[QW-2:0], 1'b0};
				end
			end
			CMD_MEAN_TAKE: begin
				mean_q <= sum_q[TB-1] ? (~qlow + 1'b1) : qlow;
			end
			CMD_MULA_LOAD: begin
				prod_q   <= '0;
				mcand_q  <= W'(sq_q);
				mplier_q <= TB'(cnt_q);
				sub_q    <= 1'b0;
			end
			CMD_MUL_STEP: begin
				if (mplier_q[0])
					prod_q <= sub_q ? (prod_q - mcand_q) : (prod_q + mcand_q);
				mcand_q  <= {mcand_q[W-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[TB-1:1]};
			end
			CMD_MULB_LOAD: begin
				mcand_q  <= W'(abs_sum);
				mplier_q <= abs_sum;
				sub_q    <= 1'b1;
			end
			CMD_DEN: begin
				den_q <= DV'(cnt_q) * DV'(cnt_q - 1'b1);
				neg_q <= prod_q[W-1];
			end
			CMD_VAR_LOAD: begin
				num_q <= {prod_q[W-2:0], {(2*FRAC){1'b0}}};
				rem_q <= '0;
				quo_q <= '0;
			end
			CMD_ROOT_LOAD: begin
				v_q   <= neg_q ? '0 : quo_q;
				res_q <= '0;
				bit_q <= {2'b01, {(QW-2){1'b0}}};
			end
			CMD_ROOT_STEP: begin
				if (v_q >= trial) begin
					v_q   <= v_q - trial;
					res_q <= {1'b0, res_q[QW-1:1]} + bit_q;
				end else begin
					res_q <= {1'b0, res_q[QW-1:1]};
				end
				bit_q <= {2'b00, bit_q[QW-1:2]};
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (ctl.op == CMD_OUT_LOAD)
			out_valid <= 1'b1;
		else if (!out_stall)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.op == CMD_OUT_LOAD) begin
			count           <= cnt_q;
			total           <= sum_q;
			smallest        <= min_q;
			largest         <= max_q;
			mean            <= mean_q;
			deviation       <= two_plus ? res_q[FIX-1:0] : '0;
			deviation_valid <= two_plus;
			dropped         <= drop_q;
		end
	end

endmodule

>>> hw/rtl/running_statistics.sv
// Running statistics over a stream of signed samples.
// Input channel: sample with in_valid/in_stall; a beat is taken when in_valid
// is high and in_stall low. Output channel: count, total, smallest, largest,
// mean, deviation, deviation_valid and dropped with out_valid/out_stall,
// one result beat for every input beat.
// The first sample runs the mean division only. Every later sample also runs
// the variance, all on one shared restoring divider (one quotient bit per
// cycle), a shift-add multiplier (one multiplier bit per cycle) and a square
// root giving one result bit per cycle. The next sample can be taken in the
// cycle after a result is loaded into the output register.
// One sample is in work at a time; in_stall is low only while idle.
// The result sits in an output register, so the next sample is taken while
// a finished result waits; a stalled receiver holds the result and blocks
// only the end of the following computation.
// Reset clears count, sum, sum of squares, minimum and maximum and drops
// any pending result. At full count a sample is ignored and flagged.
module running_statistics #(
	parameter int COUNT_BITS  = 24,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          in_valid,
	output logic                                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0]                 sample,
	output logic                                          out_valid,
	input  logic                                          out_stall,
	output logic [COUNT_BITS-1:0]                         count,
	output logic signed [COUNT_BITS+SAMPLE_BITS-1:0]      total,
	output logic signed [SAMPLE_BITS-1:0]                 smallest,
	output logic signed [SAMPLE_BITS-1:0]                 largest,
	output logic signed [SAMPLE_BITS+rstat_pkg::FRAC-1:0] mean,
	output logic [SAMPLE_BITS+rstat_pkg::FRAC-1:0]        deviation,
	output logic                                          deviation_valid,
	output logic                                          dropped
);
	import rstat_pkg::*;

	ctl_t  ctl;
	stat_t stat;

	rstat_ctrl #(
		.COUNT_BITS (COUNT_BITS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stat    (stat),
		.ctl     (ctl)
	);

	rstat_dp #(
		.COUNT_BITS (COUNT_BITS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.stat           (stat),
		.sample         (sample),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.count          (count),
		.total          (total),
		.smallest       (smallest),
		.largest        (largest),
		.mean           (mean),
		.deviation      (deviation),
		.deviation_valid(deviation_valid),
		.dropped        (dropped)
	);

endmodule

>>> hw/rtl/rstat_chk.sv
module rstat_chk #(
	parameter int COUNT_BITS  = 24,
	parameter int SAMPLE_BITS = 16
) (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   in_valid,
	input logic                                   in_stall,
	input logic                                   out_valid,
	input logic                                   out_stall,
	input logic [COUNT_BITS-1:0]                  count,
	input logic [SAMPLE_BITS+rstat_pkg::FRAC-1:0] deviation,
	input logic                                   deviation_valid,
	input logic                                   dropped
);
	import rstat_pkg::*;

	// one sample at a time: a taken beat closes the input
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input open right after a beat");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(count))
		else $error("stalled result changed");

	// only a single absorbed sample leaves the deviation invalid
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !deviation_valid |-> count == 1 && deviation == '0)
		else $error("invalid deviation with count other than one");

	// a dropped sample only at full count
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dropped |-> count == '1)
		else $error("drop below full count");

endmodule

bind running_statistics rstat_chk #(
	.COUNT_BITS (COUNT_BITS),
	.SAMPLE_BITS(SAMPLE_BITS)
) u_rstat_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.count          (count),
	.deviation      (deviation),
	.deviation_valid(deviation_valid),
	.dropped        (dropped)
);

>>> dv/tb.sv
module tb;
	import rstat_pkg::*;

	localparam int CNT_W  = 24;
	localparam int SMP_W  = 16;
	localparam int SUM_W  = CNT_W + SMP_W;
	localparam int FIX_W  = SMP_W + FRAC;
	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 400;
	localparam longint unsigned COUNT_FULL = (64'd1 << CNT_W) - 1;

	typedef struct {
		logic [CNT_W-1:0]        count;
		logic signed [SUM_W-1:0] total;
		logic signed [SMP_W-1:0] smallest;
		logic signed [SMP_W-1:0] largest;
		logic signed [FIX_W-1:0] mean;
		logic [FIX_W-1:0]        deviation;
		logic                    deviation_valid;
		logic                    dropped;
	} stats_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [SMP_W-1:0] sample;
	logic out_valid;
	logic out_stall;
	logic [CNT_W-1:0] count;
	logic signed [SUM_W-1:0] total;
	logic signed [SMP_W-1:0] smallest;
	logic signed [SMP_W-1:0] largest;
	logic signed [FIX_W-1:0] mean;
	logic [FIX_W-1:0] deviation;
	logic deviation_valid;
	logic dropped;

	// predictor state
	longint unsigned n_seen;
	longint          sum_seen;
	logic [127:0]    sumsq_seen;
	logic signed [SMP_W-1:0] min_seen;
	logic signed [SMP_W-1:0] max_seen;

	stats_t pending_stats[$];
	int     mismatches;
	int     beats_in;
	int     beats_out;
	int     idle_cycles;
	int     hold_left;
	int     stall_left;

	running_statistics #(.COUNT_BITS(CNT_W), .SAMPLE_BITS(SMP_W)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .sample(sample),
		.out_valid(out_valid), .out_stall(out_stall),
		.count(count), .total(total), .smallest(smallest), .largest(largest),
		.mean(mean), .deviation(deviation), .deviation_valid(deviation_valid),
		.dropped(dropped)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// floor of the square root, one result bit per pass
	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] probe;
		res = 0;
		probe = 64'd1 << 62;
		while (probe > v)
			probe = probe >> 2;
		while (probe != 0) begin
			if (v >= res + probe) begin
				v = v - (res + probe);
				res = (res >> 1) + probe;
			end else begin
				res = res >> 1;
			end
			probe = probe >> 2;
		end
		return res;
	endfunction

	// absorb one sample and return the statistics the block should report
	function automatic stats_t absorb_sample(input logic signed [SMP_W-1:0] s);
		stats_t r;
		longint unsigned mag;
		longint unsigned q;
		logic [127:0] scaled;
		logic [127:0] sq;
		logic [127:0] diff;
		logic [127:0] quot;
		r.dropped = n_seen >= COUNT_FULL;
		if (!r.dropped) begin
			sum_seen = sum_seen + longint'(s);
			mag = (s < 0) ? longint'(-longint'(s)) : longint'(s);
			sumsq_seen = sumsq_seen + 128'(mag * mag);
			if (n_seen == 0) begin
				min_seen = s;
				max_seen = s;
			end else begin
				if (s < min_seen) min_seen = s;
				if (s > max_seen) max_seen = s;
			end
			n_seen++;
		end
		mag = (sum_seen < 0) ? longint'(-sum_seen) : longint'(sum_seen);
		q = (mag << FRAC) / n_seen;
		r.mean = FIX_W'((sum_seen < 0) ? -q : q);
		r.deviation = '0;
		r.deviation_valid = n_seen >= 2;
		if (n_seen >= 2) begin
			scaled = 128'(n_seen) * sumsq_seen;
			sq = 128'(mag) * 128'(mag);
			if (scaled >= sq) begin
				diff = (scaled - sq) << 16;
				quot = diff / 128'(n_seen * (n_seen - 1));
				r.deviation = FIX_W'(int_sqrt(quot[63:0]));
			end
		end
		r.count = CNT_W'(n_seen);
		r.total = SUM_W'(sum_seen);
		r.smallest = min_seen;
		r.largest = max_seen;
		return r;
	endfunction

	task automatic report_mismatch(input string field, input longint got,
			input longint want);
		$display("mismatch on result %0d: %s got %0d expected %0d",
			beats_out, field, got, want);
		mismatches++;
	endtask

	// offer one sample, hold it until taken, then maybe leave a gap
	task automatic send_sample(input logic signed [SMP_W-1:0] v);
		int gap;
		in_valid <= 1'b1;
		sample <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_stats.push_back(absorb_sample(v));
		beats_in++;
		gap = ($urandom_range(0, 9) < 5) ? 0 :
			($urandom_range(0, 19) == 0) ? $urandom_range(50, 400) : $urandom_range(1, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic signed [SMP_W-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 16'sh7fff;
			1: return -16'sh8000;
			2: return SMP_W'($urandom_range(0, 8)) - 16'sd4;
			default: return SMP_W'($urandom);
		endcase
	endfunction

	// extremes, the single-sample case, sign and bit patterns
	task automatic test_directed();
		logic signed [SMP_W-1:0] pattern[$];
		pattern = '{16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000, 16'sh0000,
			-16'sh0001, 16'sh0001, 16'sh5555, 16'shaaaa, 16'sh7fff, 16'sh7fff,
			16'sh7fff, -16'sh8000, -16'sh8000, 16'sh0100, -16'sh0100};
		foreach (pattern[i])
			send_sample(pattern[i]);
	endtask

	task automatic test_random(input int items);
		repeat (items)
			send_sample(pick_sample());
	endtask

	// receiver holds off while samples keep coming, so the block backs up
	task automatic test_backpressure();
		hold_left = 1500;
		repeat (6)
			send_sample(pick_sample());
	endtask

	// sender waits for the block to drain completely, then sends more samples
	task automatic test_drain();
		in_valid <= 1'b0;
		wait (pending_stats.size() == 0);
		@(posedge clk);
		repeat (20)
			send_sample(pick_sample());
	endtask

	// result check and receiver stall
	always @(posedge clk) begin
		stats_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				beats_out++;
				if (pending_stats.size() == 0) begin
					$display("unexpected result beat %0d", beats_out);
					mismatches++;
				end else begin
					e = pending_stats.pop_front();
					if (count !== e.count) report_mismatch("count", count, e.count);
					if (total !== e.total) report_mismatch("total", total, e.total);
					if (smallest !== e.smallest)
						report_mismatch("smallest", smallest, e.smallest);
					if (largest !== e.largest)
						report_mismatch("largest", largest, e.largest);
					if (mean !== e.mean) report_mismatch("mean", mean, e.mean);
					if (deviation !== e.deviation)
						report_mismatch("deviation", deviation, e.deviation);
					if (deviation_valid !== e.deviation_valid)
						report_mismatch("deviation_valid", deviation_valid,
							e.deviation_valid);
					if (dropped !== e.dropped)
						report_mismatch("dropped", dropped, e.dropped);
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 9) < 3) begin
				stall_left = ($urandom_range(0, 15) == 0) ?
					$urandom_range(100, 600) : $urandom_range(0, 20);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample = '0;
		out_stall = 1'b0;
		n_seen = 0;
		sum_seen = 0;
		sumsq_seen = '0;
		min_seen = '0;
		max_seen = '0;
		mismatches = 0;
		beats_in = 0;
		beats_out = 0;
		idle_cycles = 0;
		hold_left = 0;
		stall_left = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(600);
		test_backpressure();
		test_drain();
		test_random(700);
		in_valid <= 1'b0;
		wait (pending_stats.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("%0d samples sent, %0d result beats checked, under random gaps",
			beats_in, beats_out);
		$display("and stalls, one long receiver hold-off and one full drain");
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
